[design/fpa_pkg.sv]
package fpa_pkg;

  // Fixed-point format of the operands and results.
  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 8;

  // Divider numerator width, which is also the number of quotient bits.
  localparam int NUM_WIDTH  = DATA_WIDTH + FRAC_BITS;
  // Working width for results before saturation.
  localparam int WIDE_WIDTH = 2 * DATA_WIDTH + 2;

  localparam logic signed [WIDE_WIDTH-1:0] MAX_WIDE =
    {{(WIDE_WIDTH-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [WIDE_WIDTH-1:0] MIN_WIDE =
    {{(WIDE_WIDTH-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_LT       = 4'd4,
    OP_GT       = 4'd5,
    OP_LE       = 4'd6,
    OP_GE       = 4'd7,
    OP_EQ       = 4'd8,
    OP_NE       = 4'd9,
    OP_MIN      = 4'd10,
    OP_MAX      = 4'd11,
    OP_INC      = 4'd12,
    OP_DEC      = 4'd13,
    OP_FROM_INT = 4'd14,
    OP_TO_INT   = 4'd15
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_DIV_ZERO = 2'd2
  } status_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] val;
    logic                  ovf;
  } sat_t;

  // Item state carried along the divider chain.
  typedef struct packed {
    logic                  is_div;
    logic                  neg;
    logic                  div_zero;
    logic [DATA_WIDTH-1:0] res;
    logic                  cmp;
    status_t               st;
    logic [NUM_WIDTH-1:0]  num;
    logic [DATA_WIDTH-1:0] den;
    logic [DATA_WIDTH-1:0] rem;
    logic [NUM_WIDTH-1:0]  quo;
  } div_pl_t;

  // Clamp a wide signed value to the signed DATA_WIDTH range.
  function automatic sat_t saturate(input logic signed [WIDE_WIDTH-1:0] v);
    sat_t s;
    s.val = v[DATA_WIDTH-1:0];
    s.ovf = 1'b0;
    if (v > MAX_WIDE) begin
      s.val = MAX_WIDE[DATA_WIDTH-1:0];
      s.ovf = 1'b1;
    end else if (v < MIN_WIDE) begin
      s.val = MIN_WIDE[DATA_WIDTH-1:0];
      s.ovf = 1'b1;
    end
    return s;
  endfunction

endpackage

[design/fpa_div_cell.sv]
module fpa_div_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  fpa_pkg::div_pl_t in_pl,
  output logic            out_valid,
  output fpa_pkg::div_pl_t out_pl
);

  logic [fpa_pkg::DATA_WIDTH:0] trial;
  logic                         fits;
  fpa_pkg::div_pl_t             pl_next;

  // One restoring step: bring down the next numerator bit and try the divisor.
  always_comb begin
    trial   = {in_pl.rem, in_pl.num[fpa_pkg::NUM_WIDTH-1]};
    fits    = trial >= {1'b0, in_pl.den};
    pl_next = in_pl;
    pl_next.num = {in_pl.num[fpa_pkg::NUM_WIDTH-2:0], 1'b0};
    pl_next.quo = {in_pl.quo[fpa_pkg::NUM_WIDTH-2:0], fits};
    if (fits) begin
      pl_next.rem = fpa_pkg::DATA_WIDTH'(trial - {1'b0, in_pl.den});
    end else begin
      pl_next.rem = trial[fpa_pkg::DATA_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_pl <= pl_next;
    end
  end

endmodule

[design/fixed_point_q24_8_alu.sv]
// Signed Q24.8 arithmetic unit: add, subtract, multiply and divide (both
// rounding half away from zero), six comparisons, min, max, increment,
// decrement, integer to fixed and fixed to integer, with saturation (status 1)
// and division by zero (status 2, result 0). It takes one item per cycle while
// the output is not held, and every item passes through the input register with
// the multiplier, the operation logic register, a chain of 40 divider cells (one
// cell per quotient bit) and the output register. When the output is held the
// whole pipeline holds with it.
module fixed_point_q24_8_alu (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // Fields from bit 0: req_type[3:0], operand_a[35:4], operand_b[67:36], zero pad.
  input  logic [71:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // Fields from bit 0: result_value[31:0], compare_true[32], status[34:33], zero pad.
  output logic [39:0] m_tdata
);

  localparam int DW = fpa_pkg::DATA_WIDTH;
  localparam int FB = fpa_pkg::FRAC_BITS;
  localparam int NW = fpa_pkg::NUM_WIDTH;
  localparam int WW = fpa_pkg::WIDE_WIDTH;

  logic en;

  // Stage 1: operands and product.
  logic                     s1_valid;
  fpa_pkg::op_t             s1_op;
  logic signed [DW-1:0]     s1_a;
  logic signed [DW-1:0]     s1_b;
  logic signed [2*DW-1:0]   s1_prod;

  // Divider chain.
  logic             c_valid [NW+1];
  fpa_pkg::div_pl_t c_pl    [NW+1];

  // Output register.
  logic                 o_valid;
  logic [DW-1:0]        o_res;
  logic                 o_cmp;
  fpa_pkg::status_t     o_st;

  assign en       = !o_valid || m_tready;
  assign s_tready = en;
  assign m_tvalid = o_valid;
  assign m_tdata  = {5'd0, o_st, o_cmp, o_res};

  // Input register with the multiplier behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_op   <= fpa_pkg::op_t'(s_tdata[3:0]);
      s1_a    <= s_tdata[35:4];
      s1_b    <= s_tdata[67:36];
      s1_prod <= $signed(s_tdata[35:4]) * $signed(s_tdata[67:36]);
    end
  end

  // Stage 2: all operations but divide, and the divider setup.
  logic signed [WW-1:0]   w_val;
  logic [2*DW-1:0]        p_mag;
  logic [2*DW-1:0]        p_rnd;
  logic [DW-1:0]          a_mag;
  logic [DW-1:0]          b_mag;
  fpa_pkg::sat_t          sat;
  fpa_pkg::div_pl_t       front;

  always_comb begin
    p_mag = s1_prod[2*DW-1] ? (2*DW)'(-s1_prod) : (2*DW)'(s1_prod);
    p_rnd = (p_mag + (2*DW)'(1 << (FB - 1))) >> FB;
    a_mag = s1_a[DW-1] ? DW'(-s1_a) : DW'(s1_a);
    b_mag = s1_b[DW-1] ? DW'(-s1_b) : DW'(s1_b);
    w_val = WW'(s1_a);
    case (s1_op)
      fpa_pkg::OP_ADD:      w_val = WW'(s1_a) + WW'(s1_b);
      fpa_pkg::OP_SUB:      w_val = WW'(s1_a) - WW'(s1_b);
      fpa_pkg::OP_MUL: begin
        w_val = $signed({2'b00, p_rnd});
        if (s1_prod[2*DW-1]) begin
          w_val = -w_val;
        end
      end
      fpa_pkg::OP_MIN:      w_val = (s1_a <= s1_b) ? WW'(s1_a) : WW'(s1_b);
      fpa_pkg::OP_MAX:      w_val = (s1_a > s1_b) ? WW'(s1_a) : WW'(s1_b);
      fpa_pkg::OP_INC:      w_val = WW'(s1_a) + WW'(1);
      fpa_pkg::OP_DEC:      w_val = WW'(s1_a) - WW'(1);
      fpa_pkg::OP_FROM_INT: w_val = WW'(s1_a) <<< FB;
      fpa_pkg::OP_TO_INT:   w_val = WW'(s1_a >>> FB);
      default:              w_val = '0;
    endcase
    sat = fpa_pkg::saturate(w_val);

    front.is_div   = (s1_op == fpa_pkg::OP_DIV);
    front.neg      = s1_a[DW-1] ^ s1_b[DW-1];
    front.div_zero = (s1_b == '0);
    front.res      = sat.val;
    front.st       = sat.ovf ? fpa_pkg::ST_OVERFLOW : fpa_pkg::ST_OK;
    front.num      = {a_mag, {FB{1'b0}}};
    front.den      = b_mag;
    front.rem      = '0;
    front.quo      = '0;
    case (s1_op)
      fpa_pkg::OP_LT: front.cmp = s1_a < s1_b;
      fpa_pkg::OP_GT: front.cmp = s1_a > s1_b;
      fpa_pkg::OP_LE: front.cmp = s1_a <= s1_b;
      fpa_pkg::OP_GE: front.cmp = s1_a >= s1_b;
      fpa_pkg::OP_EQ: front.cmp = s1_a == s1_b;
      fpa_pkg::OP_NE: front.cmp = s1_a != s1_b;
      default:        front.cmp = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid[0] <= 1'b0;
    end else if (en) begin
      c_valid[0] <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_pl[0] <= front;
    end
  end

  // Chain of divider cells, one quotient bit each.
  for (genvar i = 0; i < NW; i++) begin : g_cell
    fpa_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (c_valid[i]),
      .in_pl     (c_pl[i]),
      .out_valid (c_valid[i+1]),
      .out_pl    (c_pl[i+1])
    );
  end

  // Final rounding of the quotient and selection of the result.
  fpa_pkg::div_pl_t     tail;
  logic                 rnd_up;
  logic signed [WW-1:0] q_val;
  fpa_pkg::sat_t        q_sat;

  always_comb begin
    tail   = c_pl[NW];
    rnd_up = {tail.rem, 1'b0} >= {1'b0, tail.den};
    q_val  = $signed(WW'(tail.quo)) + WW'(rnd_up);
    if (tail.neg) begin
      q_val = -q_val;
    end
    q_sat = fpa_pkg::saturate(q_val);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (en) begin
      o_valid <= c_valid[NW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_cmp <= tail.cmp;
      if (!tail.is_div) begin
        o_res <= tail.res;
        o_st  <= tail.st;
      end else if (tail.div_zero) begin
        o_res <= '0;
        o_st  <= fpa_pkg::ST_DIV_ZERO;
      end else begin
        o_res <= q_sat.val;
        o_st  <= q_sat.ovf ? fpa_pkg::ST_OVERFLOW : fpa_pkg::ST_OK;
      end
    end
  end

`ifndef ASSERT_OFF
  // An accepted item always lands in the first stage.
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> s1_valid)
    else $error("accepted item lost at the first stage");

  // A held output keeps the whole pipeline frozen, so the last cell stays put.
  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
    (o_valid && !m_tready) |=> (c_valid[NW] == $past(c_valid[NW])))
    else $error("divider chain moved during a stall");

  // A true comparison never comes with a result value or a non-ok status.
  a_cmp_clean: assert property (@(posedge clk) disable iff (rst)
    (o_valid && o_cmp) |-> (o_res == '0 && o_st == fpa_pkg::ST_OK))
    else $error("comparison result carries data");
`endif

endmodule
